@@ rtl/imt_pkg.sv @@
// Shared types and status codes for the interval map table core.
// No dependencies.
package imt_pkg;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_WRITE_B,
        S_WRITE_E,
        S_OUT
    } t_state;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

endpackage

@@ rtl/interval_map_table_core.sv @@
// Interval map table core: sorted breakpoint table with range assign and lookup.
// Depends on imt_pkg.
//
// One request at a time: o_stall is high from acceptance until the response
// moves into the output register. A lookup passes through the scan, decide
// and output states, as does a table-full assign; an empty range goes straight
// to the output state. An assign scans, decides, runs a shift pass if entries
// must move, writes the begin and end breakpoints and then outputs. The scan
// reads entries one at a time through the single memory read port, and the
// shift pass moves one entry at a time. A response still held on the output
// keeps the core in the output state; the next request is taken once the core
// is back in idle after a response is loaded.
module interval_map_table_core #(
    parameter int CAPACITY = 64,
    parameter int KEY_W    = 32,
    parameter int VAL_W    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  logic [KEY_W-1:0] i_key_begin,
    input  logic [KEY_W-1:0] i_key_end,
    input  logic [VAL_W-1:0] i_new_value,
    input  logic [KEY_W-1:0] i_query_key,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VAL_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VAL_W-1:0] o_found_value,
    output logic [1:0]       o_status
);
    import imt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] mem_k [CAPACITY];
    logic [VAL_W-1:0] mem_v [CAPACITY];

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_src, n_src;
    logic [CW-1:0] r_dst, n_dst;
    logic          r_func, n_func;
    logic [KEY_W-1:0] r_kb, n_kb, r_ke, n_ke;
    logic [VAL_W-1:0] r_nv, n_nv;
    logic [VAL_W-1:0] r_dflt;
    logic [VAL_W-1:0] r_old, n_old, r_prev, n_prev, r_found, n_found;
    logic [VAL_W-1:0] r_ofound, n_ofound;
    logic          r_epres, n_epres;
    logic          r_insb, n_insb;
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_ostatus, n_ostatus;
    logic          r_ovalid, n_ovalid;
    logic [KEY_W-1:0] r_rk;
    logic [VAL_W-1:0] r_rv;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [KEY_W-1:0] wr_k;
    logic [VAL_W-1:0] wr_v;
    logic          ins_b;
    logic [CW:0]   newcount;
    logic [CW-1:0] fill_cnt;

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_found_value = r_ofound;
    assign o_status      = r_ostatus;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_k[wr_addr] <= wr_k;
            mem_v[wr_addr] <= wr_v;
        end
        r_rk <= mem_k[rd_addr];
        r_rv <= mem_v[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_dflt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dflt <= i_cfg_data;
            end
        end
        r_i <= n_i; r_lo <= n_lo; r_hi <= n_hi; r_src <= n_src; r_dst <= n_dst;
        r_func <= n_func; r_kb <= n_kb; r_ke <= n_ke; r_nv <= n_nv;
        r_old <= n_old; r_prev <= n_prev; r_found <= n_found;
        r_epres <= n_epres; r_insb <= n_insb; r_status <= n_status;
        r_ofound <= n_ofound; r_ostatus <= n_ostatus;
    end

    assign ins_b    = (r_prev != r_nv);
    assign newcount = {1'b0, r_cnt} - {1'b0, r_hi} + {1'b0, r_lo}
                    + {{CW{1'b0}}, ins_b} + {{CW{1'b0}}, ~r_epres};
    assign fill_cnt = r_lo + {{(CW-1){1'b0}}, ins_b} + {{(CW-1){1'b0}}, ~r_epres};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == FUNC_ASSIGN && !(i_key_begin < i_key_end)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN:       n_state = (r_i < r_cnt) ? S_SCAN_WAIT : S_DECIDE;
            S_SCAN_WAIT:  n_state = S_SCAN;
            S_DECIDE: begin
                if (r_func == FUNC_LOOKUP || newcount > (CW+1)'(CAPACITY)) begin
                    n_state = S_OUT;
                end else if (fill_cnt < r_hi || r_hi < fill_cnt) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_WRITE_B;
                end
            end
            S_SHIFT_RD:   n_state = (r_src < r_cnt) ? S_SHIFT_WAIT : S_WRITE_B;
            S_SHIFT_WAIT: n_state = S_SHIFT_WR;
            S_SHIFT_WR:   n_state = S_SHIFT_RD;
            S_WRITE_B:    n_state = S_WRITE_E;
            S_WRITE_E:    n_state = S_OUT;
            S_OUT:        n_state = (r_ovalid && i_stall) ? S_OUT : S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt = r_cnt; n_i = r_i; n_lo = r_lo; n_hi = r_hi; n_src = r_src; n_dst = r_dst;
        n_func = r_func; n_kb = r_kb; n_ke = r_ke; n_nv = r_nv;
        n_old = r_old; n_prev = r_prev; n_found = r_found;
        n_epres = r_epres; n_insb = r_insb; n_status = r_status;
        n_ofound = r_ofound; n_ostatus = r_ostatus;
        n_ovalid = r_ovalid && i_stall;
        rd_addr = r_i[AW-1:0];
        wr_en = 1'b0; wr_addr = '0; wr_k = r_kb; wr_v = r_nv;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func; n_kb = i_key_begin; n_ke = i_key_end;
                    n_nv = i_new_value;
                    if (i_func == FUNC_LOOKUP) begin
                        n_ke = i_query_key;
                    end
                    n_i = '0; n_lo = '0; n_hi = '0; n_epres = 1'b0;
                    n_old = r_dflt; n_prev = r_dflt;
                    n_status = ST_EMPTY;
                    n_found = '0;
                end
            end
            S_SCAN: rd_addr = r_i[AW-1:0];
            S_SCAN_WAIT: begin
                if (r_rk < r_kb) begin
                    n_lo = r_i + 1'b1; n_prev = r_rv;
                end
                if (r_rk < r_ke) begin
                    n_hi = r_i + 1'b1;
                end
                if (r_rk <= r_ke) begin
                    n_old = r_rv;
                end
                if (r_rk == r_ke) begin
                    n_epres = 1'b1;
                end
                n_i = r_i + 1'b1;
            end
            S_DECIDE: begin
                n_insb = ins_b;
                if (r_func == FUNC_LOOKUP) begin
                    n_found = r_old; n_status = ST_DONE;
                end else if (newcount > (CW+1)'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                    if (r_hi < fill_cnt) begin
                        n_src = r_hi; n_dst = fill_cnt;
                    end else begin
                        n_src = r_hi; n_dst = fill_cnt;
                    end
                end
            end
            S_SHIFT_RD, S_SHIFT_WAIT: begin
                // move upward from the top when growing, downward from the bottom when shrinking
                if (r_hi < fill_cnt) begin
                    rd_addr = AW'(r_cnt - 1'b1 - (r_src - r_hi));
                end else begin
                    rd_addr = r_src[AW-1:0];
                end
            end
            S_SHIFT_WR: begin
                wr_en = 1'b1;
                wr_k = r_rk; wr_v = r_rv;
                if (r_hi < fill_cnt) begin
                    wr_addr = AW'(r_cnt - 1'b1 - (r_src - r_hi) + (fill_cnt - r_hi));
                end else begin
                    wr_addr = r_dst[AW-1:0];
                end
                n_src = r_src + 1'b1; n_dst = r_dst + 1'b1;
            end
            S_WRITE_B: begin
                wr_en = r_insb; wr_addr = r_lo[AW-1:0];
                wr_k = r_kb; wr_v = r_nv;
            end
            S_WRITE_E: begin
                wr_en = ~r_epres; wr_addr = AW'(r_lo + CW'(r_insb));
                wr_k = r_ke; wr_v = r_old;
                n_cnt = newcount[CW-1:0];
            end
            S_OUT: begin
                if (!(r_ovalid && i_stall)) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_found; n_ostatus = r_status;
                end
            end
            default: ;
        endcase
    end

endmodule
